[design/bfdh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants of the double-hash bloom filter: store geometry,
// operation codes, register indexes, channel beats and controller commands.
// ----------------------------------------------------------------------------
package bfdh_pkg;

	// store geometry: rows of ROW_W bits, one valid flop per row
	localparam int MAX_BITS   = 65536;
	localparam int MAX_PROBES = 30;
	localparam int ROWS       = 256;
	localparam int ROW_W      = MAX_BITS / ROWS;
	localparam int ROW_AW     = $clog2(ROWS);
	localparam int BIT_AW     = $clog2(ROW_W);
	localparam int POS_W      = $clog2(MAX_BITS);
	localparam int SIZE_W     = POS_W + 1;
	localparam int MIN_BITS   = 64;

	localparam int HASH_W     = 32;
	localparam int KIND_W     = 2;
	localparam int ROT        = 17;
	localparam int DIV_STEPS  = HASH_W;
	localparam int DIV_CW     = $clog2(DIV_STEPS);
	localparam int PROBE_W    = $clog2(MAX_PROBES + 1);

	// configuration port
	localparam int FB_W       = 17;
	localparam int PC_W       = 5;
	localparam int CFG_W      = 17;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 2'd1;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [HASH_W-1:0] key_hash;
	} item_t;

	typedef struct packed {
		logic              present;
		logic [KIND_W-1:0] done_kind;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_CHK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic rd;
		logic chk;
		logic clr;
		logic res_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic               miss;
		logic [PROBE_W-1:0] probes_m1;
	} dp_stat_t;

endpackage
`default_nettype wire

[design/bfdh_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_dp
// Datapath: configuration registers, two bit-serial remainder units, probe
// position walk, bit store with row valid flops, result register.
// ----------------------------------------------------------------------------
module bfdh_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bfdh_pkg::item_t               req,
	input  wire logic                          cfg_we,
	input  wire logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bfdh_pkg::CFG_W-1:0]    cfg_data,
	input  wire bfdh_pkg::ctl_cmd_t            cmd,
	output bfdh_pkg::dp_stat_t                 stat,
	output bfdh_pkg::result_t                  rsp
);
	import bfdh_pkg::*;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [FB_W-1:0] fb);
		logic [31:0] s;
		s = 32'(fb);
		if (s < 32'(MIN_BITS)) s = 32'(MIN_BITS);
		if (s > 32'(MAX_BITS)) s = 32'(MAX_BITS);
		s = s & ~32'd7;
		return SIZE_W'(s);
	endfunction

	function automatic logic [PROBE_W-1:0] eff_probes_m1(input logic [PC_W-1:0] pc);
		logic [31:0] k;
		k = 32'(pc);
		if (k < 32'd1) k = 32'd1;
		if (k > 32'(MAX_PROBES)) k = 32'(MAX_PROBES);
		return PROBE_W'(k - 32'd1);
	endfunction

	logic [FB_W-1:0]   filter_bits_q;
	logic [PC_W-1:0]   probe_count_q;

	logic [KIND_W-1:0] kind_q;
	logic [HASH_W-1:0] hsh_q;
	logic [HASH_W-1:0] dsh_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  str_q;
	logic [SIZE_W-1:0] size_q;
	logic              present_q;
	result_t           rsp_q;

	logic [ROW_W-1:0]  mem [ROWS];
	logic [ROW_W-1:0]  rd_data_s2;
	logic              rd_valid_s2;
	logic [ROWS-1:0]   row_valid_q;

	logic [SIZE_W-1:0] pos_t, str_t, adv_t;
	logic [POS_W-1:0]  pos_n, str_n, pos_adv;
	logic [ROW_AW-1:0] row;
	logic [BIT_AW-1:0] bit_sel;
	logic [ROW_W-1:0]  cur_row, wr_row;
	logic              wr_en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= FB_W'(MIN_BITS);
			probe_count_q <= PC_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_BITS: filter_bits_q <= cfg_data[FB_W-1:0];
				REG_PROBE_COUNT: probe_count_q <= cfg_data[PC_W-1:0];
				default: ;
			endcase
		end
	end

	// one restoring remainder step per cycle for position and stride
	always_comb begin
		pos_t = {pos_q, hsh_q[HASH_W-1]};
		str_t = {str_q, dsh_q[HASH_W-1]};
		pos_n = (pos_t >= size_q) ? POS_W'(pos_t - size_q) : POS_W'(pos_t);
		str_n = (str_t >= size_q) ? POS_W'(str_t - size_q) : POS_W'(str_t);
		adv_t = SIZE_W'(pos_q) + SIZE_W'(str_q);
		pos_adv = (adv_t >= size_q) ? POS_W'(adv_t - size_q) : POS_W'(adv_t);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= req.kind;
			hsh_q     <= req.key_hash;
			dsh_q     <= {req.key_hash[ROT-1:0], req.key_hash[HASH_W-1:ROT]};
			pos_q     <= '0;
			str_q     <= '0;
			size_q    <= eff_size(filter_bits_q);
			present_q <= 1'b1;
		end else if (cmd.div_step) begin
			hsh_q <= hsh_q << 1;
			dsh_q <= dsh_q << 1;
			pos_q <= pos_n;
			str_q <= str_n;
		end else if (cmd.chk) begin
			pos_q <= pos_adv;
			if (cur_row[bit_sel] == 1'b0) begin
				present_q <= 1'b0;
			end
		end
		if (cmd.res_load) begin
			rsp_q.present   <= present_q & (kind_q == KIND_QUERY);
			rsp_q.done_kind <= kind_q;
		end
	end

	// bit store: row read registered, read-modify-write on insert
	assign row     = pos_q[POS_W-1:BIT_AW];
	assign bit_sel = pos_q[BIT_AW-1:0];
	assign cur_row = rd_valid_s2 ? rd_data_s2 : '0;
	assign wr_row  = cur_row | ({{(ROW_W-1){1'b0}}, 1'b1} << bit_sel);
	assign wr_en   = cmd.chk && (kind_q == KIND_INSERT);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row] <= wr_row;
		end
		if (cmd.rd) begin
			rd_data_s2  <= mem[row];
			rd_valid_s2 <= row_valid_q[row];
		end
	end

	// a row not written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.clr) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[row] <= 1'b1;
		end
	end

	assign stat.kind      = kind_q;
	assign stat.miss      = ~cur_row[bit_sel];
	assign stat.probes_m1 = eff_probes_m1(probe_count_q);
	assign rsp            = rsp_q;

endmodule
`default_nettype wire

[design/bfdh_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_ctrl
// Controller: sequences accept or clear, remainder steps, probe read/check pairs and
// hand-off of the result beat into the output register.
// ----------------------------------------------------------------------------
module bfdh_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	input  wire logic [bfdh_pkg::KIND_W-1:0] req_kind,
	output logic                             req_ready,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output bfdh_pkg::ctl_cmd_t               cmd,
	input  wire bfdh_pkg::dp_stat_t          stat
);
	import bfdh_pkg::*;

	state_t             state_q, state_d;
	logic [DIV_CW-1:0]  div_cnt_q;
	logic [PROBE_W-1:0] probe_idx_q;
	logic               rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (req_kind)
						KIND_INSERT, KIND_QUERY: state_d = ST_DIV;
						KIND_CLEAR: begin
							cmd.clr = 1'b1;
							state_d = ST_FIN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				// a query stops at its first clear bit
				if ((stat.kind == KIND_QUERY && stat.miss) ||
				    probe_idx_q == stat.probes_m1) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q   <= '0;
			probe_idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CW'(1);
			end
			if (cmd.load) begin
				probe_idx_q <= '0;
			end else if (cmd.chk) begin
				probe_idx_q <= probe_idx_q + PROBE_W'(1);
			end
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

[design/bloom_filter_double_hash.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// Bloom filter over a 64K-bit store, probes placed by double hashing of a
// precomputed key hash; insert, query and clear operations.
// ----------------------------------------------------------------------------
//  channel   signals                         beat
//  req       req_valid / req_ready / req     kind, key_hash
//  rsp       rsp_valid / rsp_ready / rsp     present, done_kind
//  cfg       cfg_we / cfg_index / cfg_data   filter_bits (0), probe_count (1)
//
//  insert/query: accept, 32 remainder steps (one hash bit per cycle), then for
//  each probe a registered store read and a check/write, then loading of the
//  result; a query ends at its first clear bit.
//  clear: all row valid flops drop at once; reset does the same.
//  a new beat is taken as soon as the result sits in the output register;
//  a stalled rsp holds the controller in its final state.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire bfdh_pkg::item_t                req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output bfdh_pkg::result_t                   rsp,
	input  wire logic                           cfg_we,
	input  wire logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bfdh_pkg::CFG_W-1:0]     cfg_data
);
	import bfdh_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	bfdh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_kind  (req.kind),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bfdh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

[design/bfdh_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_checker
// Port-level checks of the bloom filter, bound to the top level.
// ----------------------------------------------------------------------------
module bfdh_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire bfdh_pkg::item_t   req,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire bfdh_pkg::result_t rsp
);
	import bfdh_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed while stalled");

	a_rsp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.done_kind != KIND_NONE)
		else $error("result with unused kind");

	a_present_query: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.done_kind != KIND_QUERY |-> !rsp.present)
		else $error("present set on non-query result");

	// the remainder steps come before any result, so no result can follow an insert or query at once
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid &&
		(req.kind == KIND_INSERT || req.kind == KIND_QUERY) |=> !rsp_valid)
		else $error("result appeared right after insert/query beat");

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
